// ===== rtl/core/agcg_pkg.sv =====
// Shared constants, types and helpers for the affine grid cell generator.
package agcg_pkg;

  localparam int unsigned MAX_CELLS = 256;

  localparam int COL_W   = 8;
  localparam int COUNT_W = 9;
  localparam int SIZE_W  = 16;
  localparam int COEF_W  = 16;
  localparam int MROW_W  = 64;
  localparam int OUT_W   = 32;
  localparam int MUL_W   = 10;
  localparam int LOC_W   = 25;
  localparam int PROD_W  = COEF_W + LOC_W + 1;
  localparam int ACC_W   = PROD_W + 2;
  localparam int FRAC_SH = 9;
  localparam int RES_W   = ACC_W - FRAC_SH;
  localparam int STEP_W  = 3;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_CELLS_ACROSS = 3'd0;
  localparam logic [IDX_W-1:0] REG_CELLS_DEEP   = 3'd1;
  localparam logic [IDX_W-1:0] REG_CELL_WIDTH   = 3'd2;
  localparam logic [IDX_W-1:0] REG_CELL_DEPTH   = 3'd3;
  localparam logic [IDX_W-1:0] REG_MATRIX_X     = 3'd4;
  localparam logic [IDX_W-1:0] REG_MATRIX_Y     = 3'd5;
  localparam logic [IDX_W-1:0] REG_MATRIX_Z     = 3'd6;

  localparam logic [COUNT_W-1:0] CELLS_ACROSS_RST = 9'd10;
  localparam logic [COUNT_W-1:0] CELLS_DEEP_RST   = 9'd10;
  localparam logic [SIZE_W-1:0]  CELL_WIDTH_RST   = 16'd256;
  localparam logic [SIZE_W-1:0]  CELL_DEPTH_RST   = 16'd256;
  localparam logic [MROW_W-1:0]  MATRIX_X_RST     = 64'd256;
  localparam logic [MROW_W-1:0]  MATRIX_Y_RST     = 64'd16777216;
  localparam logic [MROW_W-1:0]  MATRIX_Z_RST     = 64'd1099511627776;

  localparam logic [STEP_W-1:0] STEP_CENTRE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LAST   = 3'd5;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(256);

  typedef struct packed {
    logic [COUNT_W-1:0]           cells_across;
    logic [COUNT_W-1:0]           cells_deep;
    logic [SIZE_W-1:0]            cell_width;
    logic [SIZE_W-1:0]            cell_depth;
    logic [2:0][MROW_W-1:0]       matrix;
  } cfg_t;

  typedef struct packed {
    logic kind;
    logic last;
    logic err;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [MUL_W-1:0] ax;
    logic [MUL_W-1:0] az;
  } job_t;

  function automatic logic corner_dc(input logic [STEP_W-1:0] step);
    corner_dc = (step == 3'd2) || (step == 3'd3);
  endfunction

  function automatic logic corner_dr(input logic [STEP_W-1:0] step);
    corner_dr = (step == 3'd3) || (step == 3'd4);
  endfunction

endpackage

// ===== rtl/core/agcg_cell_if.sv =====
// Input channel carrying one cell index per item.
interface agcg_cell_if;
  logic                      valid;
  logic                      ready;
  logic [agcg_pkg::COL_W-1:0] cell_column;
  logic [agcg_pkg::COL_W-1:0] cell_row;

  modport source (output valid, cell_column, cell_row, input ready);
  modport sink   (input valid, cell_column, cell_row, output ready);
endinterface

// ===== rtl/core/agcg_point_if.sv =====
// Output channel carrying one transformed point per item.
interface agcg_point_if;
  logic                              valid;
  logic                              ready;
  logic                              point_kind;
  logic signed [agcg_pkg::OUT_W-1:0] out_x;
  logic signed [agcg_pkg::OUT_W-1:0] out_y;
  logic signed [agcg_pkg::OUT_W-1:0] out_z;
  logic                              index_error;
  logic                              last_point;

  modport source (output valid, point_kind, out_x, out_y, out_z, index_error, last_point,
                  input ready);
  modport sink   (input valid, point_kind, out_x, out_y, out_z, index_error, last_point,
                  output ready);
endinterface

// ===== rtl/core/agcg_regs.sv =====
// APB configuration register file.
module agcg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [agcg_pkg::ADDR_W-1:0] paddr,
  input  logic [agcg_pkg::DATA_W-1:0] pwdata,
  output logic [agcg_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output agcg_pkg::cfg_t              cfg_o
);

  logic [agcg_pkg::COUNT_W-1:0] across_q;
  logic [agcg_pkg::COUNT_W-1:0] deep_q;
  logic [agcg_pkg::SIZE_W-1:0]  width_q;
  logic [agcg_pkg::SIZE_W-1:0]  depth_q;
  logic [agcg_pkg::MROW_W-1:0]  mx_q;
  logic [agcg_pkg::MROW_W-1:0]  my_q;
  logic [agcg_pkg::MROW_W-1:0]  mz_q;
  logic [agcg_pkg::IDX_W-1:0]   idx;
  logic                         wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[agcg_pkg::ADDR_W-1:agcg_pkg::ADDR_W-agcg_pkg::IDX_W];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= agcg_pkg::CELLS_ACROSS_RST;
      deep_q   <= agcg_pkg::CELLS_DEEP_RST;
      width_q  <= agcg_pkg::CELL_WIDTH_RST;
      depth_q  <= agcg_pkg::CELL_DEPTH_RST;
      mx_q     <= agcg_pkg::MATRIX_X_RST;
      my_q     <= agcg_pkg::MATRIX_Y_RST;
      mz_q     <= agcg_pkg::MATRIX_Z_RST;
    end else if (wr_en) begin
      case (idx)
        agcg_pkg::REG_CELLS_ACROSS: across_q <= pwdata[agcg_pkg::COUNT_W-1:0];
        agcg_pkg::REG_CELLS_DEEP:   deep_q   <= pwdata[agcg_pkg::COUNT_W-1:0];
        agcg_pkg::REG_CELL_WIDTH:   width_q  <= pwdata[agcg_pkg::SIZE_W-1:0];
        agcg_pkg::REG_CELL_DEPTH:   depth_q  <= pwdata[agcg_pkg::SIZE_W-1:0];
        agcg_pkg::REG_MATRIX_X:     mx_q     <= pwdata;
        agcg_pkg::REG_MATRIX_Y:     my_q     <= pwdata;
        agcg_pkg::REG_MATRIX_Z:     mz_q     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      agcg_pkg::REG_CELLS_ACROSS: prdata = agcg_pkg::DATA_W'(across_q);
      agcg_pkg::REG_CELLS_DEEP:   prdata = agcg_pkg::DATA_W'(deep_q);
      agcg_pkg::REG_CELL_WIDTH:   prdata = agcg_pkg::DATA_W'(width_q);
      agcg_pkg::REG_CELL_DEPTH:   prdata = agcg_pkg::DATA_W'(depth_q);
      agcg_pkg::REG_MATRIX_X:     prdata = mx_q;
      agcg_pkg::REG_MATRIX_Y:     prdata = my_q;
      agcg_pkg::REG_MATRIX_Z:     prdata = mz_q;
      default:                    prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.cells_across = across_q;
    cfg_o.cells_deep   = deep_q;
    cfg_o.cell_width   = width_q;
    cfg_o.cell_depth   = depth_q;
    cfg_o.matrix[0]    = mx_q;
    cfg_o.matrix[1]    = my_q;
    cfg_o.matrix[2]    = mz_q;
  end

endmodule

// ===== rtl/core/agcg_seq.sv =====
// Point sequencer: each cell becomes centre and corner-loop jobs, or one error job.
module agcg_seq #(
  parameter int unsigned MAX_CELLS = agcg_pkg::MAX_CELLS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  agcg_pkg::cfg_t       cfg_i,
  agcg_cell_if.sink            cell_i,
  output logic                 job_valid_o,
  output agcg_pkg::job_t       job_o,
  input  logic                 job_ready_i
);

  logic                         cur_valid_q;
  logic [agcg_pkg::STEP_W-1:0]  step_q;
  logic [agcg_pkg::COL_W-1:0]   col_q;
  logic [agcg_pkg::COL_W-1:0]   row_q;
  logic                         err_q;
  logic                         job_valid_q;
  agcg_pkg::job_t               job_q;
  agcg_pkg::job_t               job_d;
  logic                         job_en;
  logic                         cur_last;
  logic                         accept;
  logic                         in_range;
  logic [agcg_pkg::COUNT_W-1:0] col_sum;
  logic [agcg_pkg::COUNT_W-1:0] row_sum;

  assign job_en       = !job_valid_q || job_ready_i;
  assign cur_last     = err_q || (step_q == agcg_pkg::STEP_LAST);
  assign cell_i.ready = !cur_valid_q || (job_en && cur_last);
  assign accept       = cell_i.valid && cell_i.ready;
  assign job_valid_o  = job_valid_q;
  assign job_o        = job_q;

  assign in_range = ({1'b0, cell_i.cell_column} < cfg_i.cells_across)
                 && ({1'b0, cell_i.cell_row} < cfg_i.cells_deep)
                 && (int'(cell_i.cell_column) < int'(MAX_CELLS))
                 && (int'(cell_i.cell_row) < int'(MAX_CELLS));

  always_comb begin
    col_sum = {1'b0, col_q} + agcg_pkg::COUNT_W'(agcg_pkg::corner_dc(step_q));
    row_sum = {1'b0, row_q} + agcg_pkg::COUNT_W'(agcg_pkg::corner_dr(step_q));
    job_d.tag.err  = err_q;
    job_d.tag.last = cur_last;
    job_d.tag.kind = !err_q && (step_q != agcg_pkg::STEP_CENTRE);
    if (step_q == agcg_pkg::STEP_CENTRE) begin
      job_d.ax = agcg_pkg::MUL_W'({col_q, 1'b1});
      job_d.az = agcg_pkg::MUL_W'({row_q, 1'b1});
    end else begin
      job_d.ax = {col_sum, 1'b0};
      job_d.az = {row_sum, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= agcg_pkg::STEP_CENTRE;
      job_valid_q <= 1'b0;
    end else begin
      if (job_en) begin
        job_valid_q <= cur_valid_q;
      end
      if (accept) begin
        cur_valid_q <= 1'b1;
        step_q      <= agcg_pkg::STEP_CENTRE;
      end else if (job_en && cur_valid_q) begin
        if (cur_last) begin
          cur_valid_q <= 1'b0;
        end else begin
          step_q <= step_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= cell_i.cell_column;
      row_q <= cell_i.cell_row;
      err_q <= !in_range;
    end
    if (job_en) begin
      job_q <= job_d;
    end
  end

endmodule

// ===== rtl/core/agcg_xform.sv =====
// Transform pipeline: scale, multiply, accumulate, round and saturate.
module agcg_xform (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  agcg_pkg::cfg_t cfg_i,
  input  logic           job_valid_i,
  input  agcg_pkg::job_t job_i,
  output logic           job_ready_o,
  agcg_point_if.source   point_o
);

  localparam int AW = agcg_pkg::ACC_W;
  localparam int PW = agcg_pkg::PROD_W;
  localparam int CW = agcg_pkg::COEF_W;
  localparam int RW = agcg_pkg::RES_W;
  localparam int OW = agcg_pkg::OUT_W;

  localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

  logic                                    s1_valid_q;
  agcg_pkg::tag_t                          s1_tag_q;
  logic [agcg_pkg::LOC_W-1:0]              s1_x_q;
  logic [agcg_pkg::LOC_W-1:0]              s1_z_q;
  logic [agcg_pkg::MUL_W+agcg_pkg::SIZE_W-1:0] mul_x;
  logic [agcg_pkg::MUL_W+agcg_pkg::SIZE_W-1:0] mul_z;

  logic                    s2_valid_q;
  agcg_pkg::tag_t          s2_tag_q;
  logic signed [PW-1:0]    s2_px_q [3];
  logic signed [PW-1:0]    s2_pz_q [3];
  logic signed [PW-1:0]    s2_px_d [3];
  logic signed [PW-1:0]    s2_pz_d [3];

  logic                    s3_valid_q;
  agcg_pkg::tag_t          s3_tag_q;
  logic signed [AW-1:0]    s3_acc_q [3];
  logic signed [AW-1:0]    s3_acc_d [3];

  logic                    out_valid_q;
  agcg_pkg::tag_t          out_tag_q;
  logic signed [OW-1:0]    out_q [3];
  logic signed [OW-1:0]    out_d [3];
  logic signed [RW-1:0]    shifted [3];

  logic en1, en2, en3, en_out;

  assign en_out      = !out_valid_q || point_o.ready;
  assign en3         = !s3_valid_q || en_out;
  assign en2         = !s2_valid_q || en3;
  assign en1         = !s1_valid_q || en2;
  assign job_ready_o = en1;

  assign mul_x = job_i.ax * cfg_i.cell_width;
  assign mul_z = job_i.az * cfg_i.cell_depth;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s2_px_d[r] = $signed(cfg_i.matrix[r][0 +: CW]) * $signed({1'b0, s1_x_q});
      s2_pz_d[r] = $signed(cfg_i.matrix[r][2*CW +: CW]) * $signed({1'b0, s1_z_q});
      s3_acc_d[r] = AW'(s2_px_q[r]) + AW'(s2_pz_q[r])
                  + (AW'($signed(cfg_i.matrix[r][3*CW +: CW])) <<< agcg_pkg::FRAC_SH)
                  + agcg_pkg::ROUND_HALF;
      shifted[r] = $signed(s3_acc_q[r][AW-1:agcg_pkg::FRAC_SH]);
      if (s3_tag_q.err) begin
        out_d[r] = '0;
      end else if ((&shifted[r][RW-1:OW-1]) || !(|shifted[r][RW-1:OW-1])) begin
        out_d[r] = shifted[r][OW-1:0];
      end else if (shifted[r][RW-1]) begin
        out_d[r] = OUT_MIN;
      end else begin
        out_d[r] = OUT_MAX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    s1_valid_q  <= job_valid_i;
      if (en2)    s2_valid_q  <= s1_valid_q;
      if (en3)    s3_valid_q  <= s2_valid_q;
      if (en_out) out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_tag_q <= job_i.tag;
      s1_x_q   <= mul_x[agcg_pkg::LOC_W-1:0];
      s1_z_q   <= mul_z[agcg_pkg::LOC_W-1:0];
    end
    if (en2) begin
      s2_tag_q <= s1_tag_q;
      s2_px_q  <= s2_px_d;
      s2_pz_q  <= s2_pz_d;
    end
    if (en3) begin
      s3_tag_q <= s2_tag_q;
      s3_acc_q <= s3_acc_d;
    end
    if (en_out) begin
      out_tag_q <= s3_tag_q;
      out_q     <= out_d;
    end
  end

  assign point_o.valid       = out_valid_q;
  assign point_o.point_kind  = out_tag_q.kind;
  assign point_o.index_error = out_tag_q.err;
  assign point_o.last_point  = out_tag_q.last;
  assign point_o.out_x       = out_q[0];
  assign point_o.out_y       = out_q[1];
  assign point_o.out_z       = out_q[2];

endmodule

// ===== rtl/core/affine_grid_cell_generator_core.sv =====
// A cell's first point passes the job register, then s1, s2, s3 and out.
// Throughput: one point per cycle unless the output stalls; a valid cell
// gives six points, an out-of-range cell one; cells follow without a gap.
// Transform registers s1, s2, s3 and out each move if empty or if the next moves.
// Reset: rst_ni clears all valid bits and loads the default registers
// (identity transform, 10 x 10 grid of unit cells).
module affine_grid_cell_generator_core #(
  parameter int unsigned MAX_CELLS = agcg_pkg::MAX_CELLS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [agcg_pkg::ADDR_W-1:0] paddr,
  input  logic [agcg_pkg::DATA_W-1:0] pwdata,
  output logic [agcg_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  agcg_cell_if.sink                   cell_i,
  agcg_point_if.source                point_o
);

  agcg_pkg::cfg_t cfg;
  logic           job_valid;
  logic           job_ready;
  agcg_pkg::job_t job;

  agcg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  agcg_seq #(
    .MAX_CELLS (MAX_CELLS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cell_i      (cell_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  agcg_xform u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .point_o     (point_o)
  );

`ifndef ASSERT_OFF
  a_err_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_o.valid && point_o.index_error |->
      point_o.last_point && !point_o.point_kind && (point_o.out_x == 0)
      && (point_o.out_y == 0) && (point_o.out_z == 0))
    else $error("error item not a lone zero point");

  a_centre_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_o.valid && !point_o.point_kind && !point_o.index_error |-> !point_o.last_point)
    else $error("cell centre marked last");

  a_corner_no_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_o.valid && point_o.point_kind |-> !point_o.index_error)
    else $error("corner carries index error");

  a_job_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && !job_ready |=> job_valid && $stable(job))
    else $error("sequencer job changed while stalled");
`endif

endmodule
